// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the receiver RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/dcf_pkg.sv =====
// Types and frame layout constants for the DCF77 time code receiver.
// No dependencies; used by the interfaces, the result buffer and the core.
`timescale 1ns / 1ps

package dcf_pkg;

  typedef enum logic [1:0] {
    OP_RISE    = 2'd0,
    OP_FALL    = 2'd1,
    OP_TIMEOUT = 2'd2
  } dcf_op_t;

  typedef struct packed {
    dcf_op_t     operation;
    logic [15:0] elapsed_ticks;
  } dcf_event_t;

  typedef struct packed {
    logic [5:0] hour;
    logic [6:0] minute;
    logic [5:0] second;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
    logic       summer_time;
    logic       time_valid;
    logic       signal_bad;
    logic       seconds_valid;
  } dcf_result_t;

  typedef struct packed {
    logic [5:0] hour;
    logic [6:0] minute;
    logic [5:0] second;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
    logic       summer_time;
  } dcf_clock_t;

  localparam int APB_AW = 3;
  localparam logic REG_SECOND_GAP = 1'b0;
  localparam logic REG_ONE_PULSE  = 1'b1;
  localparam logic [15:0] SECOND_GAP_RESET = 16'd11700;
  localparam logic [15:0] ONE_PULSE_RESET  = 16'd2365;

  localparam int Z1_BIT      = 17;
  localparam int Z2_BIT      = 18;
  localparam int MIN_LSB     = 21;
  localparam int MIN_PAR     = 28;
  localparam int HOUR_LSB    = 29;
  localparam int HOUR_PAR    = 35;
  localparam int DATE_LSB    = 36;
  localparam int MONTH_LSB   = 45;
  localparam int YEAR_LSB    = 50;
  localparam int DATE_PAR    = 58;
  localparam int FRAME_LEN   = 59;
  localparam int MAX_INDEX   = 63;
  localparam int SEC_PER_MIN = 60;
  localparam int HR_PER_DAY  = 24;

endpackage

// ===== rtl/dcf_ifs.sv =====
// Valid/ready channel interfaces for carrier events and decoded results.
// Depends on dcf_pkg.
`timescale 1ns / 1ps

interface dcf_event_if;
  import dcf_pkg::*;
  logic       valid;
  logic       ready;
  dcf_event_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcf_result_if;
  import dcf_pkg::*;
  logic        valid;
  logic        ready;
  dcf_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dcf_obuf.sv =====
// Two-entry result buffer between the decoder state update and the result channel.
// Depends on dcf_pkg, dcf_ifs and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcf_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dcf_pkg::dcf_result_t push_data,
  output logic                full,
  dcf_result_if.source        result
);
  import dcf_pkg::*;

  dcf_result_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop          = result.valid && result.ready;
  assign full         = (count == 2'd2);
  assign result.valid = (count != 2'd0);
  assign result.data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count != 2'd3)
  `ASSERT_NEXT(a_full_holds, clk, rst, full && !pop, full)
  `ASSERT_NEXT(a_push_shows, clk, rst, push, result.valid)

endmodule

// ===== rtl/dcf77_time_code_receiver_core.sv =====
// DCF77 time code receiver core: pulse classification, parity, frame decode
// and local hh:mm:ss clock. Depends on dcf_pkg, dcf_ifs, dcf_obuf and assert_macros.svh.
//
// One carrier event is taken per clock cycle while the result buffer is not full,
// and each event yields exactly one result: the clock, date and status after that
// event, pushed into the result buffer when the event is accepted. All state updates
// for an event are done in the cycle it is accepted, from the event fields and the
// state registers. A two-entry result buffer keeps the event channel ready while one
// result waits; ready drops only when two results are waiting. Configuration
// registers sit at byte address 0 (second_gap_ticks) and 4 (one_pulse_ticks); the
// user must write them only while no event is in flight; the core does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcf77_time_code_receiver_core (
  input  logic                      clk,
  input  logic                      rst,
  dcf_event_if.sink                 item,
  dcf_result_if.source              result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dcf_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import dcf_pkg::*;

  logic [15:0] second_gap_ticks;
  logic [15:0] one_pulse_ticks;

  logic [63:0] frame_bits, frame_bits_next;
  logic [5:0]  bit_index, bit_index_next;
  logic        running_parity, running_parity_next;
  logic [2:0]  saved_parities, saved_parities_next;
  logic [15:0] tick_acc, tick_acc_next;
  logic        decode_pending, decode_pending_next;
  dcf_clock_t  clock_time, clock_time_next;
  logic        time_valid, time_valid_next;
  logic        signal_bad, signal_bad_next;
  logic        seconds_valid, seconds_valid_next;

  logic        accept;
  logic        buf_full;
  logic [15:0] acc_sum;
  logic        frame_good;
  logic        par;
  logic [7:0]  dec_minute, dec_hour, dec_day, dec_month, dec_year;
  dcf_result_t result_next;

  logic        take_rise;
  logic        take_timeout;
  logic        drop_state;
  logic        load_state;
  logic        state_hold;

  function automatic logic [7:0] bcd_value(input logic [7:0] v);
    return v - ({2'b00, v[7:4], 2'b00} + {3'b000, v[7:4], 1'b0});
  endfunction

  function automatic dcf_clock_t tick_second(input dcf_clock_t c);
    dcf_clock_t t;
    t = c;
    t.second = c.second + 6'd1;
    if (t.second == 6'(SEC_PER_MIN)) begin
      t.second = 6'd0;
      t.minute = c.minute + 7'd1;
      if (t.minute == 7'(SEC_PER_MIN)) begin
        t.minute = 7'd0;
        t.hour   = c.hour + 6'd1;
        if (t.hour == 6'(HR_PER_DAY)) begin
          t.hour = 6'd0;
        end
      end
    end
    return t;
  endfunction

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_SECOND_GAP: prdata = {16'd0, second_gap_ticks};
      REG_ONE_PULSE:  prdata = {16'd0, one_pulse_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_gap_ticks <= SECOND_GAP_RESET;
      one_pulse_ticks  <= ONE_PULSE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SECOND_GAP: second_gap_ticks <= pwdata[15:0];
        REG_ONE_PULSE:  one_pulse_ticks  <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  // event update
  assign item.ready = !buf_full;
  assign accept     = item.valid && item.ready;
  assign acc_sum    = tick_acc + item.data.elapsed_ticks;

  assign dec_minute = bcd_value({1'b0, frame_bits[MIN_LSB +: 7]});
  assign dec_hour   = bcd_value({2'b00, frame_bits[HOUR_LSB +: 6]});
  assign dec_day    = bcd_value({2'b00, frame_bits[DATE_LSB +: 6]});
  assign dec_month  = bcd_value({3'b000, frame_bits[MONTH_LSB +: 5]});
  assign dec_year   = bcd_value(frame_bits[YEAR_LSB +: 8]);

  assign frame_good = (bit_index == 6'(FRAME_LEN)) &&
                      (saved_parities[0] == frame_bits[MIN_PAR]) &&
                      (saved_parities[1] == frame_bits[HOUR_PAR]) &&
                      (saved_parities[2] == frame_bits[DATE_PAR]);

  always_comb begin
    frame_bits_next     = frame_bits;
    bit_index_next      = bit_index;
    running_parity_next = running_parity;
    saved_parities_next = saved_parities;
    tick_acc_next       = tick_acc;
    decode_pending_next = decode_pending;
    clock_time_next     = clock_time;
    time_valid_next     = time_valid;
    signal_bad_next     = signal_bad;
    seconds_valid_next  = seconds_valid;
    par                 = running_parity;
    if (accept) begin
      case (item.data.operation)
        OP_RISE: begin
          tick_acc_next = acc_sum;
          if (acc_sum > second_gap_ticks) begin
            clock_time_next = tick_second(clock_time);
            tick_acc_next   = 16'd0;
          end
          if (decode_pending) begin
            clock_time_next.minute      = dec_minute[6:0];
            clock_time_next.hour        = dec_hour[5:0];
            clock_time_next.day         = dec_day[5:0];
            clock_time_next.month       = dec_month[4:0];
            clock_time_next.year        = dec_year;
            clock_time_next.second      = 6'd0;
            clock_time_next.summer_time = frame_bits[Z1_BIT] && !frame_bits[Z2_BIT];
            frame_bits_next             = 64'd0;
            time_valid_next             = 1'b1;
            signal_bad_next             = 1'b0;
            decode_pending_next         = 1'b0;
          end
        end
        OP_FALL: begin
          tick_acc_next = acc_sum;
          if (bit_index inside {6'(MIN_LSB), 6'(HOUR_LSB), 6'(DATE_LSB)}) begin
            par = 1'b0;
          end
          if (bit_index == 6'(MIN_PAR)) begin
            saved_parities_next[0] = par;
          end
          if (bit_index == 6'(HOUR_PAR)) begin
            saved_parities_next[1] = par;
          end
          if (bit_index == 6'(DATE_PAR)) begin
            saved_parities_next[2] = par;
          end
          if (item.data.elapsed_ticks > one_pulse_ticks) begin
            frame_bits_next = frame_bits | (64'd1 << bit_index);
            par = ~par;
          end
          running_parity_next = par;
          if (bit_index != 6'(MAX_INDEX)) begin
            bit_index_next = bit_index + 6'd1;
          end
        end
        OP_TIMEOUT: begin
          seconds_valid_next = 1'b1;
          if (frame_good) begin
            decode_pending_next = 1'b1;
          end else begin
            signal_bad_next     = 1'b1;
            frame_bits_next     = 64'd0;
            decode_pending_next = 1'b0;
          end
          clock_time_next = tick_second(clock_time);
          bit_index_next  = 6'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits     <= 64'd0;
      bit_index      <= 6'd0;
      running_parity <= 1'b0;
      saved_parities <= 3'd0;
      tick_acc       <= 16'd0;
      decode_pending <= 1'b0;
      clock_time     <= '0;
      time_valid     <= 1'b0;
      signal_bad     <= 1'b0;
      seconds_valid  <= 1'b0;
    end else begin
      frame_bits     <= frame_bits_next;
      bit_index      <= bit_index_next;
      running_parity <= running_parity_next;
      saved_parities <= saved_parities_next;
      tick_acc       <= tick_acc_next;
      decode_pending <= decode_pending_next;
      clock_time     <= clock_time_next;
      time_valid     <= time_valid_next;
      signal_bad     <= signal_bad_next;
      seconds_valid  <= seconds_valid_next;
    end
  end

  always_comb begin
    result_next.hour          = clock_time_next.hour;
    result_next.minute        = clock_time_next.minute;
    result_next.second        = clock_time_next.second;
    result_next.day           = clock_time_next.day;
    result_next.month         = clock_time_next.month;
    result_next.year          = clock_time_next.year;
    result_next.summer_time   = clock_time_next.summer_time;
    result_next.time_valid    = time_valid_next;
    result_next.signal_bad    = signal_bad_next;
    result_next.seconds_valid = seconds_valid_next;
  end

  dcf_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result_next),
    .full      (buf_full),
    .result    (result)
  );

  assign take_rise    = accept && (item.data.operation == OP_RISE);
  assign take_timeout = accept && (item.data.operation == OP_TIMEOUT);
  assign drop_state   = signal_bad && !decode_pending && (frame_bits == 64'd0);
  assign load_state   = time_valid && !signal_bad && !decode_pending &&
                        (clock_time.second == 6'd0);
  assign state_hold   = (bit_index_next == bit_index) && (clock_time_next == clock_time);

  `ASSERT_NEXT(a_timeout_rewind, clk, rst, take_timeout, bit_index == 6'd0)
  `ASSERT_NEXT(a_bad_frame_drop, clk, rst, take_timeout && !frame_good, drop_state)
  `ASSERT_NEXT(a_decode_loads, clk, rst, take_rise && decode_pending, load_state)
  `ASSERT_NEXT(a_time_valid_sticks, clk, rst, time_valid, time_valid)
  `ASSERT_SAME(a_idle_holds_index, clk, rst, !accept, state_hold)

endmodule

// ===== test/dcf77_time_code_receiver_core_test.sv =====
// Self-checking testbench for dcf77_time_code_receiver_core: drives carrier events and
// APB register writes, predicts every clock/date/status readout and checks the result channel.
// Depends on dcf_pkg, dcf_ifs and the core RTL.
`timescale 1ns / 1ps

module dcf77_time_code_receiver_core_test;
  import dcf_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 270;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef enum int {FRAME_GOOD, FRAME_BAD_PARITY, FRAME_SHORT, FRAME_LONG} frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dcf_event_if carrier();
  dcf_result_if readout();

  dcf77_time_code_receiver_core u_top (
    .clk(clk),
    .rst(rst),
    .item(carrier),
    .result(readout),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // receiver state as predicted
  logic [15:0] gap_ticks = SECOND_GAP_RESET;
  logic [15:0] pulse_ticks = ONE_PULSE_RESET;
  logic [63:0] frame_word = '0;
  logic [5:0] bit_pos = '0;
  logic group_parity = 1'b0;
  logic [2:0] parity_latch = '0;
  logic [15:0] tick_sum = '0;
  logic decode_armed = 1'b0;
  dcf_clock_t clk_now = '0;
  logic time_valid_q = 1'b0;
  logic signal_bad_q = 1'b0;
  logic seconds_valid_q = 1'b0;

  dcf_event_t carrier_events[$];
  dcf_result_t clock_readouts_due[$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit idle_enabled = 1'b1;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    return v - (v >> 4) * 8'd6;
  endfunction

  function automatic logic [7:0] pack_bcd(input int unsigned v);
    return 8'((v / 10) * 16 + v % 10);
  endfunction

  function automatic string show_readout(input dcf_result_t r);
    return $sformatf("%0d:%0d:%0d %0d.%0d.%0d dst=%0d tv=%0d bad=%0d sv=%0d", r.hour,
                     r.minute, r.second, r.day, r.month, r.year, r.summer_time,
                     r.time_valid, r.signal_bad, r.seconds_valid);
  endfunction

  task automatic advance_second();
    clk_now.second = clk_now.second + 6'd1;
    if (clk_now.second == SEC_PER_MIN) begin
      clk_now.second = '0;
      clk_now.minute = clk_now.minute + 7'd1;
      if (clk_now.minute == SEC_PER_MIN) begin
        clk_now.minute = '0;
        clk_now.hour = clk_now.hour + 6'd1;
        if (clk_now.hour == HR_PER_DAY) clk_now.hour = '0;
      end
    end
  endtask

  task automatic receive_event(input dcf_event_t ev);
    logic good;
    dcf_result_t r;
    case (ev.operation)
      OP_RISE: begin
        tick_sum = tick_sum + ev.elapsed_ticks;
        if (tick_sum > gap_ticks) begin
          advance_second();
          tick_sum = '0;
        end
        if (decode_armed) begin
          decode_armed = 1'b0;
          clk_now.minute = 7'(bcd_to_bin(8'(frame_word[MIN_PAR-1:MIN_LSB])));
          clk_now.hour = 6'(bcd_to_bin(8'(frame_word[HOUR_PAR-1:HOUR_LSB])));
          clk_now.day = 6'(bcd_to_bin(8'(frame_word[DATE_LSB+5:DATE_LSB])));
          clk_now.month = 5'(bcd_to_bin(8'(frame_word[MONTH_LSB+4:MONTH_LSB])));
          clk_now.year = bcd_to_bin(frame_word[YEAR_LSB+7:YEAR_LSB]);
          clk_now.second = '0;
          clk_now.summer_time = frame_word[Z1_BIT] && !frame_word[Z2_BIT];
          frame_word = '0;
          time_valid_q = 1'b1;
          signal_bad_q = 1'b0;
        end
      end
      OP_FALL: begin
        tick_sum = tick_sum + ev.elapsed_ticks;
        if (bit_pos == MIN_LSB || bit_pos == HOUR_LSB || bit_pos == DATE_LSB)
          group_parity = 1'b0;
        if (bit_pos == MIN_PAR) parity_latch[0] = group_parity;
        if (bit_pos == HOUR_PAR) parity_latch[1] = group_parity;
        if (bit_pos == DATE_PAR) parity_latch[2] = group_parity;
        if (ev.elapsed_ticks > pulse_ticks) begin
          frame_word[bit_pos] = 1'b1;
          group_parity = ~group_parity;
        end
        if (bit_pos < MAX_INDEX) bit_pos = bit_pos + 6'd1;
      end
      OP_TIMEOUT: begin
        seconds_valid_q = 1'b1;
        good = bit_pos == FRAME_LEN && parity_latch[0] == frame_word[MIN_PAR] &&
               parity_latch[1] == frame_word[HOUR_PAR] &&
               parity_latch[2] == frame_word[DATE_PAR];
        if (good) begin
          decode_armed = 1'b1;
        end else begin
          signal_bad_q = 1'b1;
          frame_word = '0;
          decode_armed = 1'b0;
        end
        advance_second();
        bit_pos = '0;
      end
      default: ;
    endcase
    r.hour = clk_now.hour;
    r.minute = clk_now.minute;
    r.second = clk_now.second;
    r.day = clk_now.day;
    r.month = clk_now.month;
    r.year = clk_now.year;
    r.summer_time = clk_now.summer_time;
    r.time_valid = time_valid_q;
    r.signal_bad = signal_bad_q;
    r.seconds_valid = seconds_valid_q;
    clock_readouts_due.push_back(r);
  endtask

  task automatic post_carrier(input logic [1:0] code, input logic [15:0] ticks);
    dcf_event_t ev;
    ev.operation = dcf_op_t'(code);
    ev.elapsed_ticks = ticks;
    carrier_events.push_back(ev);
    queued_total++;
  endtask

  function automatic logic [15:0] rise_ticks();
    if (gap_ticks != TICKS_MAX && $urandom_range(4) != 0)
      return 16'($urandom_range(TICKS_MAX, gap_ticks + 1));
    return 16'($urandom_range(gap_ticks, 0));
  endfunction

  function automatic logic [15:0] fall_ticks(input logic one);
    if (one && pulse_ticks != TICKS_MAX)
      return 16'($urandom_range(TICKS_MAX, pulse_ticks + 1));
    return 16'($urandom_range(pulse_ticks, 0));
  endfunction

  task automatic post_minute_frame(input frame_kind_t kind);
    logic [63:0] bits;
    int unsigned len;
    bits = {$urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      bits[MIN_PAR-1:MIN_LSB] = 7'(pack_bcd($urandom_range(59)));
      bits[HOUR_PAR-1:HOUR_LSB] = 6'(pack_bcd($urandom_range(23)));
      if ($urandom_range(4) == 0) begin
        bits[MIN_PAR-1:MIN_LSB] = 7'(pack_bcd(59));
        bits[HOUR_PAR-1:HOUR_LSB] = 6'(pack_bcd(23));
      end
      bits[DATE_LSB+5:DATE_LSB] = 6'(pack_bcd($urandom_range(31, 1)));
      bits[MONTH_LSB+4:MONTH_LSB] = 5'(pack_bcd($urandom_range(12, 1)));
      bits[YEAR_LSB+7:YEAR_LSB] = pack_bcd($urandom_range(99));
    end
    if (pulse_ticks == TICKS_MAX) bits = '0;
    bits[MIN_PAR] = ^bits[MIN_PAR-1:MIN_LSB];
    bits[HOUR_PAR] = ^bits[HOUR_PAR-1:HOUR_LSB];
    bits[DATE_PAR] = ^bits[DATE_PAR-1:DATE_LSB];
    len = FRAME_LEN;
    case (kind)
      FRAME_BAD_PARITY: begin
        case ($urandom_range(2))
          0: bits[MIN_PAR] = ~bits[MIN_PAR];
          1: bits[HOUR_PAR] = ~bits[HOUR_PAR];
          default: bits[DATE_PAR] = ~bits[DATE_PAR];
        endcase
      end
      FRAME_SHORT: len = $urandom_range(FRAME_LEN - 1, 40);
      FRAME_LONG: len = $urandom_range(70, FRAME_LEN + 1);
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      post_carrier(OP_RISE, rise_ticks());
      post_carrier(OP_FALL, fall_ticks(bits[i % 64]));
    end
    post_carrier(OP_TIMEOUT, 16'($urandom));
    post_carrier(OP_RISE, rise_ticks());
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SECOND_GAP) gap_ticks = value;
    else pulse_ticks = value;
  endtask

  task automatic settle();
    while (accepted_total != queued_total || clock_readouts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : carrier_driver
    logic pause;
    pause = idle_enabled && ($urandom_range(99) < 23);
    if (rst) begin
      carrier.valid <= 1'b0;
    end else if (!carrier.valid || carrier.ready) begin
      if (!pause && carrier_events.size() != 0) begin
        carrier.valid <= 1'b1;
        carrier.data <= carrier_events.pop_front();
      end else begin
        carrier.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : readout_stall
    if (rst) readout.ready <= 1'b0;
    else readout.ready <= !(idle_enabled && ($urandom_range(99) < 23));
  end

  always @(posedge clk) begin : readout_checker
    dcf_result_t want;
    if (!rst) begin
      if (readout.valid && readout.ready) begin
        if (clock_readouts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected readout: actual %s", show_readout(readout.data));
        end else begin
          want = clock_readouts_due.pop_front();
          if (readout.data !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("readout mismatch: expected %s, actual %s", show_readout(want),
                       show_readout(readout.data));
          end
        end
      end
      if (carrier.valid && carrier.ready) begin
        accepted_total++;
        receive_event(carrier.data);
      end
      if ((carrier.valid && carrier.ready) || (readout.valid && readout.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("dcf77_time_code_receiver_core_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] gap;
    logic [15:0] pulse;
    int unsigned target;
    int unsigned broken;
    int unsigned pick;
    broken = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes, pulse and gap thresholds, unused code, bad frames
    post_carrier(OP_RISE, 16'd0);
    post_carrier(OP_RISE, TICKS_MAX);
    post_carrier(OP_RISE, SECOND_GAP_RESET);
    post_carrier(OP_RISE, 16'd1);
    post_carrier(OP_FALL, 16'd0);
    post_carrier(OP_FALL, TICKS_MAX);
    post_carrier(OP_FALL, ONE_PULSE_RESET);
    post_carrier(OP_FALL, ONE_PULSE_RESET + 16'd1);
    post_carrier(OP_UNUSED, 16'd0);
    post_carrier(OP_UNUSED, TICKS_MAX);
    post_carrier(OP_TIMEOUT, TICKS_MAX);
    post_carrier(OP_TIMEOUT, 16'd0);
    post_carrier(OP_RISE, 16'd60000);
    post_carrier(OP_RISE, 16'd10000);
    post_carrier(OP_FALL, 16'd40000);
    post_carrier(OP_RISE, 16'd30000);
    post_carrier(OP_UNUSED, 16'h5AA5);
    post_carrier(OP_TIMEOUT, 16'hA55A);
    post_carrier(OP_RISE, TICKS_MAX);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          gap = TICKS_MAX;
          pulse = 16'd1;
        end
        1: begin
          gap = 16'd1;
          pulse = TICKS_MAX;
        end
        3: begin
          gap = SECOND_GAP_RESET;
          pulse = ONE_PULSE_RESET;
        end
        default: begin
          gap = 16'($urandom_range(30000, 200));
          pulse = 16'($urandom_range(8000, 100));
        end
      endcase
      write_reg(REG_SECOND_GAP, gap);
      write_reg(REG_ONE_PULSE, pulse);
      idle_enabled = (phase != 3);
      target = queued_total + PHASE_ITEMS;
      while (queued_total < target) begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          post_minute_frame(FRAME_GOOD);
        end else if (pick < 8) begin
          case (broken % 3)
            0: post_minute_frame(FRAME_LONG);
            1: post_minute_frame(FRAME_BAD_PARITY);
            default: post_minute_frame(FRAME_SHORT);
          endcase
          broken++;
        end else begin
          repeat ($urandom_range(30, 5))
            post_carrier(2'($urandom_range(3)), 16'($urandom));
        end
      end
      settle();
    end

    if (mismatches == 0 && clock_readouts_due.size() == 0)
      $display("dcf77_time_code_receiver_core_test: PASS");
    else
      $display("dcf77_time_code_receiver_core_test: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dcf_pkg.sv
rtl/dcf_ifs.sv
rtl/dcf_obuf.sv
rtl/dcf77_time_code_receiver_core.sv
test/dcf77_time_code_receiver_core_test.sv
